// ----- sv/esls_pkg.sv -----
// Shared types, codes and constants for the slot lifecycle scheduler.
// No dependencies; the other files refer to names here by esls_pkg:: or import it.
package esls_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_BYTES = 65536;

  localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SCNT_W     = IDX_W + 1;
  localparam int PH_W       = 3;
  localparam int ADDR_W     = 48;
  localparam int CNT_W      = 5;
  localparam int REQ_W      = 3;
  localparam int ID_W       = 4;
  localparam int CS_W       = 24;
  localparam int ATTR_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  // Lifecycle phases
  localparam logic [PH_W-1:0] PH_UNINIT    = 3'd0;
  localparam logic [PH_W-1:0] PH_CREATED   = 3'd1;
  localparam logic [PH_W-1:0] PH_INIT      = 3'd2;
  localparam logic [PH_W-1:0] PH_RUNNING   = 3'd3;
  localparam logic [PH_W-1:0] PH_STOPPED   = 3'd4;
  localparam logic [PH_W-1:0] PH_DESTROYED = 3'd5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FINALIZE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ENTER    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DESTROY  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EPC_BASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HW_PRESENT = 4'd1;

  localparam logic [ADDR_W-1:0] SLOT_BYTES_A = ADDR_W'(SLOT_BYTES);
  localparam logic [CNT_W-1:0]  SLOTS_CNT    = CNT_W'(MAX_SLOTS);
  localparam logic [CS_W:0]     CODE_LIMIT   = (CS_W+1)'(SLOT_BYTES);

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [PH_W-1:0]  wr_data;
  } ram_req_t;

  function automatic logic phase_free(input logic [PH_W-1:0] p);
    return (p == PH_UNINIT) || (p == PH_DESTROYED);
  endfunction

  function automatic logic phase_live(input logic [PH_W-1:0] p);
    return (p == PH_CREATED) || (p == PH_INIT) || (p == PH_RUNNING) || (p == PH_STOPPED);
  endfunction

  function automatic logic phase_runnable(input logic [PH_W-1:0] p);
    return (p == PH_INIT) || (p == PH_STOPPED);
  endfunction

endpackage

// ----- sv/esls_if.sv -----
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on esls_pkg for field widths.
interface esls_req_if;
  logic                           valid;
  logic                           ready;
  logic [esls_pkg::REQ_W-1:0]     req_type;
  logic [esls_pkg::ID_W-1:0]      slot_id;
  logic [esls_pkg::CS_W-1:0]      code_len;
  logic [esls_pkg::ATTR_W-1:0]    attributes;
  modport source (output valid, req_type, slot_id, code_len, attributes, input ready);
  modport sink   (input valid, req_type, slot_id, code_len, attributes, output ready);
endinterface

interface esls_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [esls_pkg::ID_W-1:0]      slot;
  logic [esls_pkg::ADDR_W-1:0]    slot_base;
  logic                           dbg_en;
  logic                           encrypted;
  logic                           slot_live;
  logic [esls_pkg::CNT_W-1:0]     free_slots;
  logic [esls_pkg::CNT_W-1:0]     live_count;
  modport source (output valid, ok, slot, slot_base, dbg_en, encrypted,
                  slot_live, free_slots, live_count, input ready);
  modport sink   (input valid, ok, slot, slot_base, dbg_en, encrypted,
                  slot_live, free_slots, live_count, output ready);
endinterface

interface esls_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [esls_pkg::CFG_IDX_W-1:0]   index;
  logic [esls_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/enclave_slot_lifecycle_scheduler.sv -----
// Top level of the slot lifecycle scheduler: sequencer plus phase memory.
// Depends on esls_pkg, esls_if, esls_phase_ram and esls_ctrl.
//
//  channel  role      beat contents
//  in_ch    sink      req_type, slot_id, code_len, attributes
//  out_ch   source    ok, slot, slot_base, dbg_en, encrypted,
//                     slot_live, free_slots, live_count
//  cfg_ch   sink      index, data (0 epc_base, 1 hardware_present)
//
// One request at a time. Finalize, enter, destroy and query go read, modify/write,
// result; create and schedule scan the phase memory one slot per cycle, stopping at
// the first hit or after the last slot. Rejected beats go straight to the result.
// rst_n is synchronous; no clearing pass. A stalled result holds in the output register;
// the next request is still taken but waits in the result state until that register frees.
module enclave_slot_lifecycle_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  esls_req_if.sink    in_ch,
  esls_rsp_if.source  out_ch,
  esls_cfg_if.sink    cfg_ch
);

  esls_pkg::ram_req_t               ram_req;
  logic [esls_pkg::PH_W-1:0]        ram_rd_data;

  esls_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  esls_phase_ram u_phase_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

// ----- sv/esls_phase_ram.sv -----
// Slot phase memory: one write and one read port, registered read data.
// Depends on esls_pkg; per-entry valid bits make unwritten entries read uninitialized.
module esls_phase_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  esls_pkg::ram_req_t          req,
  output logic [esls_pkg::PH_W-1:0]   rd_data
);

  logic [esls_pkg::PH_W-1:0]      mem [esls_pkg::MAX_SLOTS];
  logic [esls_pkg::MAX_SLOTS-1:0] vld_r;
  logic [esls_pkg::PH_W-1:0]      rd_q_r;
  logic                           rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : esls_pkg::PH_UNINIT;

endmodule

// ----- sv/esls_ctrl.sv -----
// Request sequencer: decodes a beat, scans or read-modify-writes the phase
// memory, tracks free/live counts and the round-robin pointer, holds the result.
// Depends on esls_pkg and esls_if.
module esls_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  esls_req_if.sink                    in_ch,
  esls_rsp_if.source                  out_ch,
  esls_cfg_if.sink                    cfg_ch,
  output esls_pkg::ram_req_t          ram_req,
  input  logic [esls_pkg::PH_W-1:0]   ram_rd_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RMW  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  localparam int IW = esls_pkg::IDX_W;
  localparam int SW = esls_pkg::SCNT_W;
  localparam logic [SW-1:0] SLOTS_S = SW'(esls_pkg::MAX_SLOTS);

  logic [1:0]                      state_r, state_nxt;
  logic [esls_pkg::REQ_W-1:0]      req_r, req_nxt;
  logic [IW-1:0]                   id_r, id_nxt;
  logic                            dbg_r, dbg_nxt;
  logic [IW-1:0]                   start_r, start_nxt;
  logic [SW-1:0]                   cnt_r, cnt_nxt;
  logic                            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]                   chk_idx_r, chk_idx_nxt;
  logic                            chk_last_r, chk_last_nxt;
  logic [IW-1:0]                   last_r, last_nxt;
  logic                            have_r, have_nxt;
  logic [esls_pkg::CNT_W-1:0]      free_r, free_nxt;
  logic [esls_pkg::CNT_W-1:0]      live_r, live_nxt;
  logic [esls_pkg::ADDR_W-1:0]     epc_base_r;
  logic                            hw_r;

  logic                            res_ok_r, res_ok_nxt;
  logic [IW-1:0]                   res_slot_r, res_slot_nxt;
  logic [esls_pkg::ADDR_W-1:0]     res_base_r, res_base_nxt;
  logic                            res_dbg_r, res_dbg_nxt;
  logic                            res_enc_r, res_enc_nxt;
  logic                            res_live_r, res_live_nxt;

  logic                            out_valid_r;
  logic                            out_ok_r;
  logic [esls_pkg::ID_W-1:0]       out_slot_r;
  logic [esls_pkg::ADDR_W-1:0]     out_base_r;
  logic                            out_dbg_r;
  logic                            out_enc_r;
  logic                            out_live_r;
  logic [esls_pkg::CNT_W-1:0]      out_free_r;
  logic [esls_pkg::CNT_W-1:0]      out_cnt_r;

  logic                            in_fire;
  logic                            id_ok;
  logic                            out_free;
  logic                            out_load;
  logic [SW-1:0]                   iss_sum;
  logic [IW-1:0]                   iss_idx;
  logic                            hit;
  logic [SW-1:0]                   next_start;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign id_ok        = ({1'b0, in_ch.slot_id} < (esls_pkg::ID_W+1)'(esls_pkg::MAX_SLOTS));
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = (state_r == ST_RESP) && out_free;
  assign cfg_ch.ready = 1'b1;

  // Scan position wraps once at most: start and count both stay below the slot count.
  assign iss_sum    = SW'(start_r) + cnt_r;
  assign iss_idx    = (iss_sum >= SLOTS_S) ? IW'(iss_sum - SLOTS_S) : IW'(iss_sum);
  assign next_start = SW'(last_r) + SW'(1);
  assign hit        = (req_r == esls_pkg::REQ_CREATE) ? esls_pkg::phase_free(ram_rd_data)
                                                      : esls_pkg::phase_runnable(ram_rd_data);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    id_nxt       = id_r;
    dbg_nxt      = dbg_r;
    start_nxt    = start_r;
    cnt_nxt      = cnt_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    chk_last_nxt = chk_last_r;
    last_nxt     = last_r;
    have_nxt     = have_r;
    free_nxt     = free_r;
    live_nxt     = live_r;
    res_ok_nxt   = res_ok_r;
    res_slot_nxt = res_slot_r;
    res_base_nxt = res_base_r;
    res_dbg_nxt  = res_dbg_r;
    res_enc_nxt  = res_enc_r;
    res_live_nxt = res_live_r;
    ram_req      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt      = in_ch.req_type;
          id_nxt       = in_ch.slot_id[IW-1:0];
          dbg_nxt      = in_ch.attributes[0];
          cnt_nxt      = '0;
          chk_vld_nxt  = 1'b0;
          res_ok_nxt   = 1'b0;
          res_slot_nxt = '0;
          res_base_nxt = '0;
          res_dbg_nxt  = 1'b0;
          res_enc_nxt  = 1'b0;
          res_live_nxt = 1'b0;
          state_nxt    = ST_RESP;
          case (in_ch.req_type)
            esls_pkg::REQ_CREATE: begin
              start_nxt = '0;
              if ({1'b0, in_ch.code_len} <= esls_pkg::CODE_LIMIT) begin
                state_nxt = ST_SCAN;
              end
            end
            esls_pkg::REQ_SCHEDULE: begin
              start_nxt = '0;
              if (have_r && (next_start < SLOTS_S)) begin
                start_nxt = IW'(next_start);
              end
              have_nxt  = 1'b0;
              last_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            esls_pkg::REQ_FINALIZE, esls_pkg::REQ_ENTER,
            esls_pkg::REQ_DESTROY, esls_pkg::REQ_QUERY: begin
              if (id_ok) begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = in_ch.slot_id[IW-1:0];
                state_nxt       = ST_RMW;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, check the one issued the cycle before.
        if (cnt_r < SLOTS_S) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = iss_idx;
          cnt_nxt         = cnt_r + SW'(1);
          chk_vld_nxt     = 1'b1;
          chk_idx_nxt     = iss_idx;
          chk_last_nxt    = (cnt_r == SLOTS_S - SW'(1));
        end
        if (chk_vld_r) begin
          if (hit) begin
            res_ok_nxt   = 1'b1;
            res_slot_nxt = chk_idx_r;
            chk_vld_nxt  = 1'b0;
            state_nxt    = ST_RESP;
            if (req_r == esls_pkg::REQ_CREATE) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = chk_idx_r;
              ram_req.wr_data = esls_pkg::PH_CREATED;
              res_base_nxt    = epc_base_r + esls_pkg::ADDR_W'(chk_idx_r) * esls_pkg::SLOT_BYTES_A;
              res_dbg_nxt     = dbg_r;
              res_enc_nxt     = hw_r;
              free_nxt        = free_r - esls_pkg::CNT_W'(1);
              if (live_r < esls_pkg::SLOTS_CNT) begin
                live_nxt = live_r + esls_pkg::CNT_W'(1);
              end
            end else begin
              last_nxt = chk_idx_r;
              have_nxt = 1'b1;
            end
          end else if (chk_last_r) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_RESP;
          end
        end
      end

      ST_RMW: begin
        state_nxt       = ST_RESP;
        ram_req.wr_addr = id_r;
        case (req_r)
          esls_pkg::REQ_FINALIZE: begin
            if (ram_rd_data == esls_pkg::PH_CREATED) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_data = esls_pkg::PH_INIT;
              res_ok_nxt      = 1'b1;
            end
          end
          esls_pkg::REQ_ENTER: begin
            if (esls_pkg::phase_runnable(ram_rd_data)) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_data = esls_pkg::PH_STOPPED;
              res_ok_nxt      = 1'b1;
            end
          end
          esls_pkg::REQ_DESTROY: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_data = esls_pkg::PH_DESTROYED;
            res_ok_nxt      = 1'b1;
            if (esls_pkg::phase_live(ram_rd_data) && (live_r != '0)) begin
              live_nxt = live_r - esls_pkg::CNT_W'(1);
            end
            if (!esls_pkg::phase_free(ram_rd_data)) begin
              free_nxt = free_r + esls_pkg::CNT_W'(1);
            end
          end
          esls_pkg::REQ_QUERY: begin
            res_ok_nxt   = 1'b1;
            res_live_nxt = esls_pkg::phase_live(ram_rd_data);
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
      end

      ST_RESP: begin
        // Hold until the output register frees up.
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      last_r      <= '0;
      have_r      <= 1'b0;
      free_r      <= esls_pkg::SLOTS_CNT;
      live_r      <= '0;
      epc_base_r  <= '0;
      hw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      last_r    <= last_nxt;
      have_r    <= have_nxt;
      free_r    <= free_nxt;
      live_r    <= live_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == esls_pkg::CFG_EPC_BASE) begin
          epc_base_r <= cfg_ch.data[esls_pkg::ADDR_W-1:0];
        end
        if (cfg_ch.index == esls_pkg::CFG_HW_PRESENT) begin
          hw_r <= cfg_ch.data[0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    id_r       <= id_nxt;
    dbg_r      <= dbg_nxt;
    start_r    <= start_nxt;
    cnt_r      <= cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    chk_last_r <= chk_last_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_base_r <= res_base_nxt;
    res_dbg_r  <= res_dbg_nxt;
    res_enc_r  <= res_enc_nxt;
    res_live_r <= res_live_nxt;
    if (out_load) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= esls_pkg::ID_W'(res_slot_r);
      out_base_r <= res_base_r;
      out_dbg_r  <= res_dbg_r;
      out_enc_r  <= res_enc_r;
      out_live_r <= res_live_r;
      out_free_r <= free_r;
      out_cnt_r  <= live_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.slot_base  = out_base_r;
  assign out_ch.dbg_en     = out_dbg_r;
  assign out_ch.encrypted  = out_enc_r;
  assign out_ch.slot_live  = out_live_r;
  assign out_ch.free_slots = out_free_r;
  assign out_ch.live_count = out_cnt_r;

endmodule

// ----- verif/esls_lifecycle_checker.sv -----
`timescale 1ns / 1ps
// Lifecycle checker: follows the request, config and result channels of the slot scheduler,
// keeps its own slot table and compares every result beat with the oldest prediction.
// Depends on esls_pkg and the channel interfaces in esls_if.
module esls_lifecycle_checker (
  input  logic clk,
  input  logic rst_n,
  esls_req_if  req_mon,
  esls_rsp_if  rsp_mon,
  esls_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import esls_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   slot;
    logic [ADDR_W-1:0] slot_base;
    logic              dbg_en;
    logic              encrypted;
    logic              slot_live;
    logic [CNT_W-1:0]  free_slots;
    logic [CNT_W-1:0]  live_count;
  } slot_result_t;

  logic [PH_W-1:0]   phase_tbl [MAX_SLOTS];
  logic [IDX_W-1:0]  rr_last;
  logic              rr_armed;
  logic [CNT_W-1:0]  live_total;
  logic [ADDR_W-1:0] epc_base;
  logic              hw_present;
  slot_result_t      awaited[$];
  int                mismatches;
  int                beat_no;

  function automatic logic vacant(input logic [PH_W-1:0] p);
    return (p == PH_UNINIT) || (p == PH_DESTROYED);
  endfunction

  function automatic logic holds_enclave(input logic [PH_W-1:0] p);
    return (p >= PH_CREATED) && (p <= PH_STOPPED);
  endfunction

  function automatic logic runnable(input logic [PH_W-1:0] p);
    return (p == PH_INIT) || (p == PH_STOPPED);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: result beat %0d, %s: got 'h%0h, expected 'h%0h",
             $time, beat_no, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Apply one request to the slot table and queue the result it must produce.
  task automatic predict_request(input logic [REQ_W-1:0] rq, input logic [ID_W-1:0] id,
                                 input logic [CS_W-1:0] code_len,
                                 input logic [ATTR_W-1:0] attr);
    slot_result_t     r;
    logic             id_ok;
    logic [IDX_W-1:0] sid;
    int               scan;
    int               pick;
    int               at;
    int               n_free;
    r     = '0;
    id_ok = (id < MAX_SLOTS);
    sid   = id[IDX_W-1:0];
    case (rq)
      REQ_CREATE: begin
        if (code_len <= SLOT_BYTES) begin
          for (scan = 0; scan < MAX_SLOTS && !r.ok; scan++) begin
            if (vacant(phase_tbl[scan])) begin
              phase_tbl[scan] = PH_CREATED;
              r.ok            = 1'b1;
              r.slot          = ID_W'(scan);
              r.slot_base     = epc_base + ADDR_W'(scan) * SLOT_BYTES_A;
              r.dbg_en        = attr[0];
              r.encrypted     = hw_present;
              if (live_total < SLOTS_CNT) live_total = live_total + 1'b1;
            end
          end
        end
      end
      REQ_FINALIZE: begin
        if (id_ok && phase_tbl[sid] == PH_CREATED) begin
          phase_tbl[sid] = PH_INIT;
          r.ok           = 1'b1;
        end
      end
      REQ_ENTER: begin
        if (id_ok && runnable(phase_tbl[sid])) begin
          phase_tbl[sid] = PH_STOPPED;
          r.ok           = 1'b1;
        end
      end
      REQ_DESTROY: begin
        if (id_ok) begin
          // a slot that is already free leaves the live total alone
          if (holds_enclave(phase_tbl[sid]) && live_total != '0)
            live_total = live_total - 1'b1;
          phase_tbl[sid] = PH_DESTROYED;
          r.ok           = 1'b1;
        end
      end
      REQ_SCHEDULE: begin
        pick     = rr_armed ? (int'(rr_last) + 1) % MAX_SLOTS : 0;
        rr_armed = 1'b0;
        rr_last  = '0;
        for (scan = 0; scan < MAX_SLOTS && !r.ok; scan++) begin
          at = (pick + scan) % MAX_SLOTS;
          if (runnable(phase_tbl[at])) begin
            rr_last  = IDX_W'(at);
            rr_armed = 1'b1;
            r.ok     = 1'b1;
            r.slot   = ID_W'(at);
          end
        end
      end
      REQ_QUERY: begin
        if (id_ok) begin
          r.ok        = 1'b1;
          r.slot_live = holds_enclave(phase_tbl[sid]);
        end
      end
      default: ;
    endcase
    n_free = 0;
    for (scan = 0; scan < MAX_SLOTS; scan++)
      if (vacant(phase_tbl[scan])) n_free++;
    r.free_slots = CNT_W'(n_free);
    r.live_count = live_total;
    awaited.push_back(r);
  endtask

  always @(posedge clk) begin : monitor
    slot_result_t want;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < MAX_SLOTS; i++) phase_tbl[i] = PH_UNINIT;
      rr_last    = '0;
      rr_armed   = 1'b0;
      live_total = '0;
      epc_base   = '0;
      hw_present = 1'b0;
      awaited.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_EPC_BASE:   epc_base   = cfg_mon.data[ADDR_W-1:0];
          CFG_HW_PRESENT: hw_present = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        predict_request(req_mon.req_type, req_mon.slot_id, req_mon.code_len,
                        req_mon.attributes);
      if (rsp_mon.valid && rsp_mon.ready) begin
        beat_no++;
        if (awaited.size() == 0) begin
          report_mismatch("result beat with no request outstanding", '0, '0);
        end else begin
          want = awaited.pop_front();
          check_field("ok", 64'(rsp_mon.ok), 64'(want.ok));
          check_field("slot", 64'(rsp_mon.slot), 64'(want.slot));
          check_field("slot_base", 64'(rsp_mon.slot_base), 64'(want.slot_base));
          check_field("dbg_en", 64'(rsp_mon.dbg_en), 64'(want.dbg_en));
          check_field("encrypted", 64'(rsp_mon.encrypted), 64'(want.encrypted));
          check_field("slot_live", 64'(rsp_mon.slot_live), 64'(want.slot_live));
          check_field("free_slots", 64'(rsp_mon.free_slots), 64'(want.free_slots));
          check_field("live_count", 64'(rsp_mon.live_count), 64'(want.live_count));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= awaited.size();
  end

endmodule

// ----- verif/enclave_slot_lifecycle_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the slot lifecycle scheduler: clock, reset, config writes and request
// stimulus with randomized source idling and sink stalls; the checker does the comparison.
// Depends on esls_pkg, esls_if, the scheduler RTL and esls_lifecycle_checker.
module enclave_slot_lifecycle_scheduler_tb;
  import esls_pkg::*;

  // Watchdog on the whole run of roughly 1400 request beats with random gaps and stalls;
  // the limit leaves a wide margin over the slowest correct beats.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 336;
  localparam int SETTLE_CYCLES = MAX_SLOTS + 4;

  // request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   cycles        = 0;
  int   fail_count;
  int   pending;

  esls_req_if in_ch();
  esls_rsp_if out_ch();
  esls_cfg_if cfg_ch();

  enclave_slot_lifecycle_scheduler u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  esls_lifecycle_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one request beat, idling first at the current source rate.
  task automatic issue(input logic [REQ_W-1:0] rq, input logic [ID_W-1:0] id,
                       input logic [CS_W-1:0] code_len, input logic [ATTR_W-1:0] attr);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.req_type   <= REQ_W'($urandom);
      in_ch.slot_id    <= ID_W'($urandom);
      in_ch.code_len   <= CS_W'($urandom);
      in_ch.attributes <= $urandom;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rq;
    in_ch.slot_id    <= id;
    in_ch.code_len   <= code_len;
    in_ch.attributes <= attr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic issue_random;
    logic [REQ_W-1:0] rq;
    logic [ID_W-1:0]  id;
    logic [CS_W-1:0]  cs;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 28)      rq = REQ_CREATE;
    else if (roll < 44) rq = REQ_FINALIZE;
    else if (roll < 60) rq = REQ_ENTER;
    else if (roll < 72) rq = REQ_DESTROY;
    else if (roll < 86) rq = REQ_SCHEDULE;
    else if (roll < 97) rq = REQ_QUERY;
    else                rq = ($urandom_range(1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
    // mostly live slot ids so lifecycles advance; some out of range
    id = ($urandom_range(99) < 88) ? ID_W'($urandom_range(MAX_SLOTS - 1)) : ID_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 70)      cs = CS_W'($urandom_range(SLOT_BYTES));
    else if (roll < 80) cs = CS_W'(SLOT_BYTES);
    else                cs = CS_W'($urandom);
    issue(rq, id, cs, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result, then let the block settle.
  task automatic drain;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = '0;
    in_ch.slot_id    = '0;
    in_ch.code_len   = '0;
    in_ch.attributes = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state: nothing live, nothing runnable
    issue(REQ_QUERY, 4'd0, '0, '0);
    issue(REQ_SCHEDULE, '0, '0, '0);
    drain();

    // top-of-range base so slot addresses wrap
    write_reg(CFG_EPC_BASE, '1);
    write_reg(CFG_HW_PRESENT, CFG_DATA_W'(1));
    issue(REQ_CREATE, '0, '1, '1);
    issue(REQ_CREATE, '0, CS_W'(SLOT_BYTES + 1), '1);
    issue(REQ_CREATE, '1, CS_W'(SLOT_BYTES), '1);
    issue(REQ_CREATE, '0, '0, 32'hFFFF_FFFE);
    issue(REQ_FINALIZE, '1, '0, '0);
    issue(REQ_FINALIZE, 4'd0, '0, '0);
    issue(REQ_FINALIZE, 4'd0, '0, '0);
    issue(REQ_ENTER, 4'd1, '0, '0);
    issue(REQ_ENTER, 4'd0, '0, '0);
    issue(REQ_ENTER, 4'd0, '0, '0);
    issue(REQ_SCHEDULE, '0, '0, '0);
    issue(REQ_SCHEDULE, '0, '0, '0);
    issue(REQ_DESTROY, 4'd0, '0, '0);
    issue(REQ_DESTROY, 4'd0, '0, '0);
    issue(REQ_DESTROY, 4'd7, '0, '0);
    issue(REQ_DESTROY, 4'd8, '0, '0);
    issue(REQ_QUERY, 4'd1, '0, '0);
    issue(REQ_SPARE_HI, 4'd1, '0, '0);
    // fill every free slot, then one create too many
    repeat (MAX_SLOTS) issue(REQ_CREATE, '0, '0, 32'h1);

    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
          write_reg(CFG_EPC_BASE, '0);
          write_reg(CFG_HW_PRESENT, '0);
        end
        1: begin
          src_idle_pct  = 56;
          snk_stall_pct = 0;
          write_reg(CFG_EPC_BASE, CFG_DATA_W'({$urandom, $urandom}));
          write_reg(CFG_HW_PRESENT, CFG_DATA_W'(1));
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 56;
          write_reg(CFG_EPC_BASE, '1);
          write_reg(CFG_HW_PRESENT, '0);
        end
        default: begin
          src_idle_pct  = 37;
          snk_stall_pct = 37;
          write_reg(CFG_EPC_BASE, CFG_DATA_W'({$urandom, $urandom}));
          write_reg(CFG_HW_PRESENT, CFG_DATA_W'({$urandom, $urandom}));
        end
      endcase
      repeat (PHASE_ITEMS) issue_random();
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
